// File: hw/rtl/frame_saturation_and_mean_stats_defines.svh
// ----------------------------------------------------------------------------
// Frame statistics assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_SATURATION_AND_MEAN_STATS_DEFINES_SVH
`define FRAME_SATURATION_AND_MEAN_STATS_DEFINES_SVH

// same-cycle implication
`define FSMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fsms_pkg.sv
// ----------------------------------------------------------------------------
// Frame statistics package
// Payload types, register indexes and fixed widths of the frame statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsms_pkg;

    localparam int PIX_W      = 16;
    localparam int DIM_W      = 14;
    localparam int CNT_W      = 13;
    localparam int COL_OUT_W  = 12;
    localparam int SUM_W      = 40;
    localparam int VCNT_W     = 25;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = 24;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int DIVISOR_W  = VCNT_W;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_ONE  = MEAN_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] column_index;
        logic [CNT_W-1:0]     column_saturated;
        logic                 frame_done;
        logic [MEAN_W-1:0]    frame_mean;
    } res_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/fsms_chan_if.sv
// ----------------------------------------------------------------------------
// Frame statistics channel
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsms_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/frame_saturation_and_mean_stats.sv
// An accepted pixel passes through the stage 1 registers and then into the output register.
// Throughput: one pixel per cycle, set by the read-modify-write of the column RAM,
// while the output is not stalled; the last pixel of a frame waits for the mean divider.
// Reset: geometry and level registers take their defaults, counters clear, and
// the column RAM is zeroed in a pass over all MAX_WIDTH addresses
// that holds off the pixel input.
// ----------------------------------------------------------------------------
// Frame saturation and mean statistics
// Per-column saturated pixel counts held in RAM, and the truncated mean of
// the valid pixels of each frame in unsigned 16.8 fixed point, no lower than 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_saturation_and_mean_stats_defines.svh"

module frame_saturation_and_mean_stats #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    fsms_chan_if.sink    cfg,
    fsms_chan_if.sink    pixels,
    fsms_chan_if.source  results
);

    import fsms_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
    localparam logic [CW-1:0]    CLR_LAST = CW'(MAX_WIDTH - 1);

    // configuration
    logic [PIX_W-1:0] sat_level_reg;
    logic [CNT_W-1:0] frame_width_reg;
    logic [CNT_W-1:0] frame_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_level_reg    <= PIX_W'(16383);
            frame_width_reg  <= CNT_W'(4096);
            frame_height_reg <= CNT_W'(4096);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_SAT_LEVEL:    sat_level_reg    <= cfg.data.value;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data.value[CNT_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data.value[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // column RAM clearing pass after reset
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    // stage 0: geometry, sums, RAM read
    logic [CW-1:0]     col_pos_reg, col_pos_next;
    logic [RW-1:0]     row_pos_reg, row_pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_upd, sum_next;
    logic [VCNT_W-1:0] vcnt_reg, vcnt_upd, vcnt_next;

    logic [PIX_W-1:0] pix;
    logic [DIM_W-1:0] w_eff, h_eff, col_inc, row_inc;
    logic             row_end, frame_end, pix_sat, pix_valid;
    logic             in_fire;

    // stage 1
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_sat_reg;
    logic             s1_row0_reg;
    logic             s1_done_reg;
    logic             s1_zero_reg;
    logic             s1_fwd_reg;
    logic [CNT_W-1:0] s1_fwd_cnt_reg;
    logic             s1_adv;

    logic [CNT_W-1:0] ram_rdata, cnt_old, cnt_new;
    logic             ram_we;
    logic [CW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic             div_busy;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [MEAN_W-1:0] mean_val;

    logic      out_valid_reg;
    res_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == CLR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        pix       = PIX_W'(pixels.data.pixel_value[PIXEL_BITS-1:0]);
        pix_sat   = pix > sat_level_reg;
        pix_valid = pix < sat_level_reg;

        w_eff = DIM_W'(frame_width_reg);
        if (w_eff == '0)
        begin
            w_eff = DIM_ONE;
        end
        else if (w_eff > MAX_W_D)
        begin
            w_eff = MAX_W_D;
        end
        h_eff = DIM_W'(frame_height_reg);
        if (h_eff == '0)
        begin
            h_eff = DIM_ONE;
        end
        else if (h_eff > MAX_H_D)
        begin
            h_eff = MAX_H_D;
        end

        col_inc   = DIM_W'(col_pos_reg) + DIM_ONE;
        row_inc   = DIM_W'(row_pos_reg) + DIM_ONE;
        row_end   = col_inc >= w_eff;
        frame_end = row_end && (row_inc >= h_eff);

        sum_upd  = pix_valid ? (sum_reg + SUM_W'(pix)) : sum_reg;
        vcnt_upd = pix_valid ? (vcnt_reg + VCNT_W'(1)) : vcnt_reg;

        if (frame_end)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
            sum_next     = '0;
            vcnt_next    = '0;
        end
        else if (row_end)
        begin
            col_pos_next = '0;
            row_pos_next = row_inc[RW-1:0];
            sum_next     = sum_upd;
            vcnt_next    = vcnt_upd;
        end
        else
        begin
            col_pos_next = col_inc[CW-1:0];
            row_pos_next = row_pos_reg;
            sum_next     = sum_upd;
            vcnt_next    = vcnt_upd;
        end
    end

    assign s1_adv = s1_valid_reg && (!out_valid_reg || results.ready)
                    && (!s1_done_reg || !div_busy);
    assign pixels.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_fire = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            sum_reg      <= '0;
            vcnt_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                sum_reg     <= sum_next;
                vcnt_reg    <= vcnt_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // forward the count written in the same cycle as this read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg     <= col_pos_reg;
            s1_sat_reg     <= pix_sat;
            s1_row0_reg    <= (row_pos_reg == '0);
            s1_done_reg    <= frame_end;
            s1_zero_reg    <= (vcnt_upd == '0);
            s1_fwd_reg     <= s1_adv && (s1_col_reg == col_pos_reg);
            s1_fwd_cnt_reg <= cnt_new;
        end
    end

    assign ram_we    = clr_busy_reg || s1_adv;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wdata = clr_busy_reg ? '0 : cnt_new;

    fsms_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (col_pos_reg),
        .rdata (ram_rdata)
    );

    fsms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire && frame_end),
        .dividend ({sum_upd, {FRAC_W{1'b0}}}),
        .divisor  (vcnt_upd),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // stage 1: modify count, floor the mean
    always_comb
    begin
        cnt_old = s1_fwd_reg ? s1_fwd_cnt_reg : ram_rdata;
        if (s1_row0_reg)
        begin
            cnt_new = CNT_W'(s1_sat_reg);
        end
        else if (s1_sat_reg && (cnt_old != COUNT_MAX))
        begin
            cnt_new = cnt_old + CNT_W'(1);
        end
        else
        begin
            cnt_new = cnt_old;
        end

        if (s1_zero_reg || (div_quo[DIVIDEND_W-1:FRAC_W] == '0))
        begin
            mean_val = MEAN_ONE;
        end
        else
        begin
            mean_val = div_quo[MEAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_item_reg.column_index     <= COL_OUT_W'(s1_col_reg);
            out_item_reg.column_saturated <= cnt_new;
            out_item_reg.frame_done       <= s1_done_reg;
            out_item_reg.frame_mean       <= s1_done_reg ? mean_val : '0;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

    `FSMS_ASSERT_NOW(a_mean_floor, clk, rst_n,
        results.valid && results.data.frame_done,
        results.data.frame_mean >= MEAN_ONE, "frame mean below 1.0 on frame end")
    `FSMS_ASSERT_NOW(a_mean_zero, clk, rst_n,
        results.valid && !results.data.frame_done,
        results.data.frame_mean == '0, "frame mean set on a pixel that ends no frame")
    `FSMS_ASSERT_NEXT(a_div_start, clk, rst_n,
        in_fire && frame_end,
        div_busy && s1_valid_reg && s1_done_reg, "frame end did not start the divider")
    `FSMS_ASSERT_NOW(a_col_range, clk, rst_n,
        1'b1,
        DIM_W'(col_pos_reg) < MAX_W_D, "column position beyond RAM depth")

endmodule

`default_nettype wire

// File: hw/rtl/fsms_ram.sv
// ----------------------------------------------------------------------------
// Frame statistics RAM
// Simple dual-port RAM, one write and one read port, registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module fsms_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fsms_div.sv
// ----------------------------------------------------------------------------
// Frame statistics divider
// Restoring radix-2 divider, one quotient bit per cycle, for the frame mean.
// ----------------------------------------------------------------------------
`default_nettype none

module fsms_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fsms_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [fsms_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            busy,
    output logic [fsms_pkg::DIVIDEND_W-1:0] quotient
);

    import fsms_pkg::*;

    localparam int REM_W = DIVISOR_W + 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W:0]   diff;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[DIVIDEND_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = ~diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[REM_W-1:0] : rem_shift;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
